>>> hdl/tld_pkg.sv
// Shared types and constants for the tty line discipline.
// Holds character codes, register indexes, FSM states and the control/status bundles.
// No dependencies.
`default_nettype none

package tld_pkg;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_DEL = 8'h7F;

    localparam int CAP_W = 6;

    localparam logic [1:0] REG_ECHO_ENABLE      = 2'd0;
    localparam logic [1:0] REG_IN_NEWLINE_CRLF  = 2'd1;
    localparam logic [1:0] REG_OUT_NEWLINE_CRLF = 2'd2;
    localparam logic [1:0] REG_LINE_CAPACITY    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_STORE_LF,
        ST_ECHO_CR,
        ST_ECHO_CHAR,
        ST_LINE_CHECK,
        ST_LINE_FETCH,
        ST_LINE_SEND
    } tld_state_t;

    typedef struct packed {
        logic accept;
        logic store_cr;
        logic store_char;
        logic drop;
        logic echo_cr;
        logic echo_char;
        logic line_start;
        logic line_emit;
    } tld_cmd_t;

    typedef struct packed {
        logic is_del;
        logic is_lf;
        logic fill_zero;
        logic crlf_room;
        logic line_end;
        logic line_last;
        logic out_free;
    } tld_sts_t;

endpackage

`default_nettype wire

>>> hdl/tld_datapath.sv
// Datapath of the tty line discipline: line store, fill count, output register.
// Driven by tld_controller through tld_cmd_t; uses tld_pkg.
`default_nettype none

module tld_datapath
    import tld_pkg::*;
#(
    parameter int LINE_DEPTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire tld_cmd_t         cmd,
    output tld_sts_t              sts,
    input  wire logic [7:0]       s_received_byte,
    input  wire logic [CAP_W-1:0] line_capacity,
    input  wire logic             m_ready,
    output logic                  m_valid,
    output logic                  m_channel,
    output logic [7:0]            m_data_byte,
    output logic                  m_last
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);

    logic [7:0]    mem [LINE_DEPTH];
    logic [7:0]    char_reg;
    logic [7:0]    rd_data_reg;
    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic          m_valid_reg, m_valid_next;
    logic          m_channel_reg;
    logic [7:0]    m_data_reg;
    logic          m_last_reg;
    logic [CW-1:0] cap;
    logic          is_cr;
    logic          store_ok;
    logic          out_load;
    logic [AW-1:0] rd_idx_inc;

    // Clamp capacity into 1..LINE_DEPTH
    always_comb begin
        if (line_capacity == '0) begin
            cap = CW'(1);
        end else if (line_capacity > CAP_W'(LINE_DEPTH)) begin
            cap = CW'(LINE_DEPTH);
        end else begin
            cap = CW'(line_capacity);
        end
    end

    assign is_cr         = (char_reg == CH_CR);
    assign store_ok      = (fill_reg < CW'(LINE_DEPTH));
    assign rd_idx_inc    = rd_idx_reg + AW'(1);

    assign sts.is_del    = (char_reg == CH_DEL);
    assign sts.is_lf     = (char_reg == CH_LF);
    assign sts.fill_zero = (fill_reg == '0);
    assign sts.crlf_room = ((CW + 1)'(fill_reg) + (CW + 1)'(1)) < (CW + 1)'(cap);
    assign sts.line_end  = is_cr || sts.is_lf || (fill_reg >= cap);
    assign sts.line_last = ((CW'(rd_idx_reg) + CW'(1)) == fill_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign out_load = cmd.echo_cr || cmd.echo_char || cmd.line_emit;

    always_comb begin
        fill_next = fill_reg;
        if (cmd.drop) begin
            fill_next = fill_reg - CW'(1);
        end else if ((cmd.store_cr || cmd.store_char) && store_ok) begin
            fill_next = fill_reg + CW'(1);
        end else if (cmd.line_emit && sts.line_last) begin
            fill_next = '0;
        end
    end

    always_comb begin
        rd_idx_next = rd_idx_reg;
        if (cmd.line_start) begin
            rd_idx_next = '0;
        end else if (cmd.line_emit) begin
            rd_idx_next = rd_idx_inc;
        end
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            rd_idx_reg  <= rd_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Line store: one write port at the fill point, one registered read port
    always_ff @(posedge aclk) begin
        if ((cmd.store_cr || cmd.store_char) && store_ok) begin
            mem[fill_reg[AW-1:0]] <= cmd.store_cr ? CH_CR : char_reg;
        end
        if (cmd.line_start) begin
            rd_data_reg <= mem[0];
        end else if (cmd.line_emit && ((CW'(rd_idx_reg) + CW'(1)) < CW'(LINE_DEPTH))) begin
            // prefetch the next entry while this one goes out
            rd_data_reg <= mem[rd_idx_inc];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            char_reg <= s_received_byte;
        end
        if (cmd.echo_cr) begin
            m_channel_reg <= 1'b0;
            m_data_reg    <= CH_CR;
            m_last_reg    <= 1'b0;
        end else if (cmd.echo_char) begin
            m_channel_reg <= 1'b0;
            m_data_reg    <= char_reg;
            m_last_reg    <= !sts.line_end;
        end else if (cmd.line_emit) begin
            m_channel_reg <= 1'b1;
            m_data_reg    <= rd_data_reg;
            m_last_reg    <= sts.line_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_channel   = m_channel_reg;
    assign m_data_byte = m_data_reg;
    assign m_last      = m_last_reg;

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.store_cr, cmd.store_char, cmd.drop, cmd.echo_cr, cmd.echo_char,
                  cmd.line_start, cmd.line_emit}))
        else $error("more than one datapath command at once");

    a_store_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.store_cr || cmd.store_char) |-> store_ok)
        else $error("line store written while full");

    a_line_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.line_emit && sts.line_last) |=> (fill_reg == '0))
        else $error("fill count not cleared after last line byte");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> sts.out_free)
        else $error("output register overwritten before transfer");

endmodule

`default_nettype wire

>>> hdl/tld_controller.sv
// Controller FSM of the tty line discipline.
// Sequences store, echo and line drain through tld_cmd_t; uses tld_pkg.
`default_nettype none

module tld_controller
    import tld_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire logic     echo_enable,
    input  wire logic     in_newline_crlf,
    input  wire logic     out_newline_crlf,
    input  wire tld_sts_t sts,
    output tld_cmd_t      cmd
);

    tld_state_t state_reg, state_next;
    tld_state_t echo_target;

    always_comb begin
        if (!echo_enable) begin
            echo_target = ST_LINE_CHECK;
        end else if (sts.is_lf && out_newline_crlf) begin
            echo_target = ST_ECHO_CR;
        end else begin
            echo_target = ST_ECHO_CHAR;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                if (sts.is_del && sts.fill_zero) begin
                    state_next = ST_IDLE;
                end else if (sts.is_lf && in_newline_crlf && sts.crlf_room) begin
                    state_next = ST_STORE_LF;
                end else begin
                    state_next = echo_target;
                end
            end
            ST_STORE_LF: state_next = echo_target;
            ST_ECHO_CR: begin
                if (sts.out_free) state_next = ST_ECHO_CHAR;
            end
            ST_ECHO_CHAR: begin
                if (sts.out_free) state_next = sts.line_end ? ST_LINE_FETCH : ST_IDLE;
            end
            ST_LINE_CHECK: state_next = sts.line_end ? ST_LINE_FETCH : ST_IDLE;
            ST_LINE_FETCH: state_next = ST_LINE_SEND;
            ST_LINE_SEND: begin
                if (sts.out_free && sts.line_last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_DECODE: begin
                if (sts.is_del) begin
                    cmd.drop = !sts.fill_zero;
                end else if (sts.is_lf && in_newline_crlf && sts.crlf_room) begin
                    cmd.store_cr = 1'b1;
                end else begin
                    cmd.store_char = 1'b1;
                end
            end
            ST_STORE_LF:   cmd.store_char = 1'b1;
            ST_ECHO_CR:    cmd.echo_cr    = sts.out_free;
            ST_ECHO_CHAR:  cmd.echo_char  = sts.out_free;
            ST_LINE_CHECK: cmd            = '0;
            ST_LINE_FETCH: cmd.line_start = 1'b1;
            ST_LINE_SEND:  cmd.line_emit  = sts.out_free;
            default:       cmd            = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == ST_DECODE))
        else $error("accepted character not decoded next cycle");

    a_fetch_send: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.line_start |=> (state_reg == ST_LINE_SEND))
        else $error("line fetch not followed by drain");

    a_echo_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.echo_cr |=> (state_reg == ST_ECHO_CHAR))
        else $error("echoed CR not followed by the character");

endmodule

`default_nettype wire

>>> hdl/tty_line_discipline.sv
// Top level of the tty line discipline: APB register file plus controller and datapath.
// Instantiates tld_controller and tld_datapath; uses tld_pkg.
//
// Canonical line editing for one terminal. Each received character is taken on the s_
// channel and answered on the m_ channel by zero or more transfers: up to two echo bytes
// (channel 0) and, when the line ends on CR, LF or a full store, the stored line (channel 1);
// m_last marks the final transfer of a character. Line bytes are fetched from the line
// store through a registered read and leave through a one-entry output register, one line
// byte per cycle while m_ready is high; a new character is taken only once the previous
// one is done. Registers: 0x0 echo_enable, 0x4 in_newline_crlf, 0x8 out_newline_crlf,
// 0xC line_capacity (0 acts as 1, above LINE_DEPTH as LINE_DEPTH).
// Write registers only while no character is in flight.
`default_nettype none

module tty_line_discipline
    import tld_pkg::*;
#(
    parameter int LINE_DEPTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_received_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_channel,
    output logic [7:0]       m_data_byte,
    output logic             m_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic             echo_enable_reg;
    logic             in_crlf_reg;
    logic             out_crlf_reg;
    logic [CAP_W-1:0] capacity_reg;
    logic             cfg_write;
    logic [1:0]       reg_index;
    tld_cmd_t         cmd;
    tld_sts_t         sts;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_enable_reg <= 1'b1;
            in_crlf_reg     <= 1'b1;
            out_crlf_reg    <= 1'b1;
            capacity_reg    <= CAP_W'(32);
        end else if (cfg_write) begin
            case (reg_index)
                REG_ECHO_ENABLE:      echo_enable_reg <= pwdata[0];
                REG_IN_NEWLINE_CRLF:  in_crlf_reg     <= pwdata[0];
                REG_OUT_NEWLINE_CRLF: out_crlf_reg    <= pwdata[0];
                REG_LINE_CAPACITY:    capacity_reg    <= pwdata[CAP_W-1:0];
                default:              capacity_reg    <= capacity_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_ECHO_ENABLE:      prdata = {31'd0, echo_enable_reg};
            REG_IN_NEWLINE_CRLF:  prdata = {31'd0, in_crlf_reg};
            REG_OUT_NEWLINE_CRLF: prdata = {31'd0, out_crlf_reg};
            REG_LINE_CAPACITY:    prdata = {{(32 - CAP_W){1'b0}}, capacity_reg};
            default:              prdata = '0;
        endcase
    end

    tld_controller u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .echo_enable      (echo_enable_reg),
        .in_newline_crlf  (in_crlf_reg),
        .out_newline_crlf (out_crlf_reg),
        .sts              (sts),
        .cmd              (cmd)
    );

    tld_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_received_byte (s_received_byte),
        .line_capacity   (capacity_reg),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_channel       (m_channel),
        .m_data_byte     (m_data_byte),
        .m_last          (m_last)
    );

endmodule

`default_nettype wire
